>>> sv/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MaxBlocks   = 256;
  localparam int unsigned MaxWaiters  = 16;
  localparam int unsigned HeaderBytes = 8;

  localparam int unsigned IdxW   = $clog2(MaxBlocks);
  localparam int unsigned CntW   = $clog2(MaxBlocks + 1);
  localparam int unsigned WIdxW  = $clog2(MaxWaiters);
  localparam int unsigned WCntW  = $clog2(MaxWaiters + 1);

  // Operation codes
  localparam logic [1:0] OpCreate  = 2'd0;
  localparam logic [1:0] OpDelete  = 2'd1;
  localparam logic [1:0] OpAlloc   = 2'd2;
  localparam logic [1:0] OpRelease = 2'd3;

  // Status codes
  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StErr  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;

  // Register indexes
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegBlock = 2'd1;
  localparam logic [1:0] RegPool  = 2'd2;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

>>> sv/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal blocks with a memory-held free stack and a waiter queue.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   set base address, block size and pool size; they take effect at create.
//   Requests enter on s_axis (tdata: mode, no_wait, task_id, release_address)
//   and one result per request leaves on m_axis (tdata: status,
//   granted_address, woke_valid, woke_task, free_left).
//   One request is handled at a time. Delete goes straight to the result,
//   allocate does one free-stack memory read, create runs the serial divider
//   and then pushes each block (up to 256) as the stack memory is written one
//   entry a cycle, and release runs the serial divider, plus a wake step when
//   a task is waiting.
//   The result sits in an output register; a stalled receiver holds it and
//   no new request is taken until it is delivered.
//   Reset clears the pool, the counts and the queue pointers; the memories
//   are not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] mode, [2] no_wait, [10:3] task_id, [42:11] release_address, pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] granted_address, [34] woke_valid,
  // [42:35] woke_task, [51:43] free_left, pad
  output logic [55:0] m_axis_tdata
);
  import fbpa_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SFill  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SWake  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [31:0] cfg_base_q;
  logic [15:0] cfg_block_q;
  logic [31:0] cfg_pool_q;

  logic [31:0] lat_base_q, lat_base_d;
  logic [16:0] lat_pitch_q, lat_pitch_d;
  logic [CntW-1:0] lat_blocks_q, lat_blocks_d;
  logic        valid_q, valid_d;
  logic [CntW-1:0] free_q, free_d;
  logic [WIdxW-1:0] whead_q, whead_d, wtail_q, wtail_d;
  logic [WCntW-1:0] wcnt_q, wcnt_d;

  logic [1:0]  op_q, op_d;
  logic [7:0]  task_q, task_d;
  logic [31:0] raddr_q, raddr_d;
  logic [CntW-1:0] fill_q, fill_d;

  logic [1:0]  rst_status_q, rst_status_d;
  logic [31:0] raddr_out_q, raddr_out_d;
  logic        woke_q, woke_d;
  logic [7:0]  wtask_q, wtask_d;
  logic [CntW-1:0] rfree_q, rfree_d;
  logic        mvalid_q, mvalid_d;

  // Free stack memory and waiter queue memory
  logic [IdxW-1:0] stack_mem [MaxBlocks];
  logic [7:0]      wait_mem  [MaxWaiters];
  logic            st_we;
  logic [IdxW-1:0] st_waddr, st_raddr, st_wdata, st_rdata;
  logic            wq_we;
  logic [7:0]      wq_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [16:0] pitch_w;
  logic [31:0] first_w;
  logic [31:0] off_w;
  logic [31:0] mul_w;
  logic        accept;

  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == SIdle) && !mvalid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pitch_w       = {1'b0, cfg_block_q} + 17'(HeaderBytes);
  assign first_w       = lat_base_q + 32'(HeaderBytes);
  assign off_w         = raddr_q - first_w;
  assign mul_w         = 32'(st_rdata) * 32'(lat_pitch_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= 32'd0;
      cfg_block_q <= 16'd0;
      cfg_pool_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBase:  cfg_base_q  <= cfg_data_i;
        RegBlock: cfg_block_q <= cfg_data_i[15:0];
        RegPool:  cfg_pool_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Memories: synchronous write, registered read
  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    st_rdata <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wq_we) wait_mem[wtail_q] <= task_q;
    wq_rdata <= wait_mem[whead_q];
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    lat_base_d   = lat_base_q;
    lat_pitch_d  = lat_pitch_q;
    lat_blocks_d = lat_blocks_q;
    valid_d      = valid_q;
    free_d       = free_q;
    whead_d      = whead_q;
    wtail_d      = wtail_q;
    wcnt_d       = wcnt_q;
    op_d         = op_q;
    task_d       = task_q;
    raddr_d      = raddr_q;
    fill_d       = fill_q;
    rst_status_d = rst_status_q;
    raddr_out_d  = raddr_out_q;
    woke_d       = woke_q;
    wtask_d      = wtask_q;
    rfree_d      = rfree_q;
    mvalid_d     = mvalid_q;
    st_we        = 1'b0;
    st_waddr     = fill_q[IdxW-1:0];
    st_wdata     = fill_q[IdxW-1:0];
    st_raddr     = IdxW'(free_q - CntW'(1));
    wq_we        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cfg_pool_q;
    div_req.divisor  = 32'(pitch_w);

    if (mvalid_q && m_axis_tready) mvalid_d = 1'b0;

    case (state_q)
      SIdle: begin
        if (accept) begin
          op_d        = s_axis_tdata[1:0];
          task_d      = s_axis_tdata[10:3];
          raddr_d     = s_axis_tdata[42:11];
          rst_status_d = StErr;
          raddr_out_d = 32'd0;
          woke_d      = 1'b0;
          wtask_d     = 8'd0;
          state_d     = SOut;
          case (s_axis_tdata[1:0])
            OpCreate: begin
              if (cfg_block_q != 16'd0 && cfg_pool_q != 32'd0 &&
                  cfg_pool_q >= 32'(pitch_w)) begin
                div_req.start = 1'b1;
                state_d = SDiv;
              end
            end
            OpDelete: begin
              if (valid_q) begin
                valid_d = 1'b0;
                rst_status_d = StDone;
              end
            end
            OpAlloc: begin
              if (valid_q) begin
                if (free_q != '0) begin
                  state_d = SRead;
                end else if (!s_axis_tdata[2] && wcnt_q < WCntW'(MaxWaiters)) begin
                  rst_status_d = StWait;
                end
              end
            end
            default: begin
              if (valid_q && lat_pitch_q != '0 &&
                  s_axis_tdata[42:11] >= first_w) begin
                div_req.start    = 1'b1;
                div_req.dividend = s_axis_tdata[42:11] - first_w;
                div_req.divisor  = 32'(lat_pitch_q);
                state_d = SDiv;
              end
            end
          endcase
        end
      end
      SDiv: begin
        div_req.dividend = off_w;
        div_req.divisor  = 32'(lat_pitch_q);
        if (div_rsp.done) begin
          if (op_q == OpCreate) begin
            lat_blocks_d = (div_rsp.quotient > 32'(MaxBlocks)) ?
                           CntW'(MaxBlocks) : CntW'(div_rsp.quotient);
            lat_base_d   = cfg_base_q;
            lat_pitch_d  = pitch_w;
            fill_d       = '0;
            state_d      = SFill;
          end else if (div_rsp.remainder == 32'd0 &&
                       div_rsp.quotient < 32'(lat_blocks_q) &&
                       free_q < lat_blocks_q) begin
            st_we    = 1'b1;
            st_waddr = free_q[IdxW-1:0];
            st_wdata = div_rsp.quotient[IdxW-1:0];
            free_d   = free_q + CntW'(1);
            rst_status_d = StDone;
            state_d  = (wcnt_q != '0) ? SWake : SOut;
          end else begin
            state_d = SOut;
          end
        end
      end
      SFill: begin
        if (fill_q == lat_blocks_q) begin
          free_d  = lat_blocks_q;
          valid_d = 1'b1;
          rst_status_d = StDone;
          state_d = SOut;
        end else begin
          st_we  = 1'b1;
          fill_d = fill_q + CntW'(1);
        end
      end
      SRead: begin
        raddr_out_d  = lat_base_q + mul_w + 32'(HeaderBytes);
        free_d       = free_q - CntW'(1);
        rst_status_d = StDone;
        state_d      = SOut;
      end
      SWake: begin
        woke_d  = 1'b1;
        wtask_d = wq_rdata;
        whead_d = whead_q + WIdxW'(1);
        wcnt_d  = wcnt_q - WCntW'(1);
        state_d = SOut;
      end
      SOut: begin
        // A queued caller is written at the tail once its task id is held.
        if (op_q == OpAlloc && rst_status_q == StWait) begin
          wq_we   = 1'b1;
          wtail_d = wtail_q + WIdxW'(1);
          wcnt_d  = wcnt_q + WCntW'(1);
        end
        rfree_d  = free_q;
        mvalid_d = 1'b1;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      lat_base_q   <= 32'd0;
      lat_pitch_q  <= '0;
      lat_blocks_q <= '0;
      valid_q      <= 1'b0;
      free_q       <= '0;
      whead_q      <= '0;
      wtail_q      <= '0;
      wcnt_q       <= '0;
      mvalid_q     <= 1'b0;
      fill_q       <= '0;
    end else begin
      state_q      <= state_d;
      lat_base_q   <= lat_base_d;
      lat_pitch_q  <= lat_pitch_d;
      lat_blocks_q <= lat_blocks_d;
      valid_q      <= valid_d;
      free_q       <= free_d;
      whead_q      <= whead_d;
      wtail_q      <= wtail_d;
      wcnt_q       <= wcnt_d;
      mvalid_q     <= mvalid_d;
      fill_q       <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    task_q       <= task_d;
    raddr_q      <= raddr_d;
    rst_status_q <= rst_status_d;
    raddr_out_q  <= raddr_out_d;
    woke_q       <= woke_d;
    wtask_q      <= wtask_d;
    rfree_q      <= rfree_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {4'd0, rfree_q, wtask_q, woke_q, raddr_out_q, rst_status_q};

endmodule

>>> sv/fbpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbpa_pkg::div_req_t req_i,
  output fbpa_pkg::div_rsp_t rsp_o
);
  import fbpa_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.dividend;
      rem_d  = 32'd0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> bench/fixed_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Self-checking bench for the fixed block pool allocator. Requests are queued
// by an initial block in phases, each after the first opening with register
// writes while the block is idle. A clocked driver sends them with random
// gaps, a local pool model predicts every reply, and a clocked monitor with
// random back-pressure compares each reply field by field.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  typedef struct packed {
    logic [31:0] raddr;
    logic [7:0]  tid;
    logic        no_wait;
    logic [1:0]  mode;
  } pool_req_t;

  typedef struct packed {
    logic [8:0]  free_left;
    logic [7:0]  woke_task;
    logic        woke_valid;
    logic [31:0] granted;
    logic [1:0]  status;
  } pool_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  pool_req_t   req_queue[$];
  pool_reply_t due_replies[$];
  int          mismatches;
  bit          burst;

  // Shadow of the registers and of the pool held by the block.
  logic [31:0] reg_base, reg_pool;
  logic [15:0] reg_block;
  logic [7:0]  free_ids[MaxBlocks];
  logic [8:0]  free_cnt;
  bit          pool_ok;
  logic [7:0]  waiters[MaxWaiters];
  logic [3:0]  wait_rd, wait_wr;
  logic [4:0]  wait_cnt;
  logic [31:0] pool_base, pool_pitch, pool_blocks;

  fixed_block_pool_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Work out the reply to one accepted request and update the pool shadow.
  task automatic pool_predict(input pool_req_t rq);
    pool_reply_t rp;
    logic [31:0] pitch, nblk, first, off, idx;
    rp = '0;
    case (rq.mode)
      OpCreate: begin
        pitch = {16'd0, reg_block} + HeaderBytes;
        if (reg_block == 0 || reg_pool == 0 || reg_pool < pitch) begin
          rp.status = StErr;
        end else begin
          nblk = reg_pool / pitch;
          if (nblk > MaxBlocks) nblk = MaxBlocks;
          for (int i = 0; i < nblk; i++) free_ids[i] = i[7:0];
          free_cnt    = nblk[8:0];
          pool_blocks = nblk;
          pool_base   = reg_base;
          pool_pitch  = pitch;
          pool_ok     = 1'b1;
          rp.status   = StDone;
        end
      end
      OpDelete: begin
        rp.status = pool_ok ? StDone : StErr;
        pool_ok   = 1'b0;
      end
      OpAlloc: begin
        if (!pool_ok) begin
          rp.status = StErr;
        end else if (free_cnt == 0) begin
          if (rq.no_wait || wait_cnt >= MaxWaiters) begin
            rp.status = StErr;
          end else begin
            waiters[wait_wr] = rq.tid;
            wait_wr   = wait_wr + 1'b1;
            wait_cnt  = wait_cnt + 1'b1;
            rp.status = StWait;
          end
        end else begin
          free_cnt   = free_cnt - 1'b1;
          rp.granted = pool_base + free_ids[free_cnt[7:0]] * pool_pitch + HeaderBytes;
          rp.status  = StDone;
        end
      end
      default: begin
        first = pool_base + HeaderBytes;
        off   = rq.raddr - first;
        rp.status = StErr;
        if (pool_ok && pool_pitch != 0 && rq.raddr >= first && off % pool_pitch == 0)
        begin
          idx = off / pool_pitch;
          if (idx < pool_blocks && free_cnt < pool_blocks) begin
            free_ids[free_cnt[7:0]] = idx[7:0];
            free_cnt  = free_cnt + 1'b1;
            rp.status = StDone;
            if (wait_cnt > 0) begin
              rp.woke_valid = 1'b1;
              rp.woke_task  = waiters[wait_rd];
              wait_rd  = wait_rd + 1'b1;
              wait_cnt = wait_cnt - 1'b1;
            end
          end
        end
      end
    endcase
    rp.free_left = free_cnt;
    due_replies.push_back(rp);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Request driver: random gaps between requests, none while in a burst.
  int req_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      req_gap = 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        pool_predict(pool_req_t'(s_axis_tdata[42:0]));
        req_gap = burst ? 0 : $urandom_range(0, 18);
      end
      if (req_gap == 0 && req_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, req_queue.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
        if (req_gap > 0) req_gap--;
      end
    end
  end

  // Reply monitor: random stalls, every reply checked against the oldest one due.
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pool_reply_t'(m_axis_tdata[51:0]);
        if (due_replies.size() == 0) begin
          report("unexpected reply", got[31:0], 32'd0);
        end else begin
          want = due_replies.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.granted != want.granted) report("granted_address", got.granted, want.granted);
          if (got.woke_valid != want.woke_valid)
            report("woke_valid", got.woke_valid, want.woke_valid);
          if (got.woke_task != want.woke_task)
            report("woke_task", got.woke_task, want.woke_task);
          if (got.free_left != want.free_left)
            report("free_left", got.free_left, want.free_left);
        end
        stall = burst ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) stall--;
      m_axis_tready <= (stall == 0);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegBase:  reg_base  = val;
      RegBlock: reg_block = val[15:0];
      default:  reg_pool  = val;
    endcase
  endtask

  task automatic add_req(input logic [1:0] mode, input logic nw, input logic [31:0] addr);
    pool_req_t rq;
    rq.mode    = mode;
    rq.no_wait = nw;
    rq.tid     = 8'($urandom_range(0, 255));
    rq.raddr   = addr;
    req_queue.push_back(rq);
  endtask

  // Wait until every request has gone and every reply has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (req_queue.size() > 0 || s_axis_tvalid || due_replies.size() > 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_pool(input logic [31:0] b, input logic [15:0] bs, input logic [31:0] ps);
    drain();
    write_reg(RegBase, b);
    write_reg(RegBlock, {16'd0, bs});
    write_reg(RegPool, ps);
  endtask

  // Payload address of block k of the current register setting.
  function automatic logic [31:0] slot_addr(input int k);
    return reg_base + k * ({16'd0, reg_block} + HeaderBytes) + HeaderBytes;
  endfunction

  // One phase of mostly well-formed traffic against the current setting.
  task automatic random_phase(input int count);
    int r, nblk;
    logic [31:0] pitch, a;
    pitch = {16'd0, reg_block} + HeaderBytes;
    nblk  = (reg_pool / pitch > MaxBlocks) ? MaxBlocks : reg_pool / pitch;
    add_req(OpCreate, 1'b0, $urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        add_req(OpAlloc, $urandom_range(0, 3) == 0, $urandom);
      end else if (r < 84) begin
        a = slot_addr($urandom_range(0, nblk));
        if ($urandom_range(0, 6) == 0) a = a + $urandom_range(1, pitch - 1);
        if ($urandom_range(0, 9) == 0) a = $urandom;
        add_req(OpRelease, 1'($urandom_range(0, 1)), a);
      end else if (r < 87) begin
        add_req(OpDelete, 1'($urandom_range(0, 1)), $urandom);
      end else if (r < 91) begin
        add_req(OpCreate, 1'($urandom_range(0, 1)), $urandom);
      end else begin
        add_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  initial begin
    int nblk;
    logic [15:0] bs;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    reg_base = '0; reg_block = '0; reg_pool = '0;
    free_cnt = '0; pool_ok = 1'b0;
    wait_rd = '0; wait_wr = '0; wait_cnt = '0;
    pool_base = '0; pool_pitch = '0; pool_blocks = '0;
    mismatches = 0;
    burst = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: nothing valid yet, then the invalid size cases.
    add_req(OpDelete, 1'b0, 32'd0);
    add_req(OpAlloc, 1'b0, 32'd0);
    add_req(OpRelease, 1'b0, 32'd8);
    add_req(OpCreate, 1'b0, 32'd0);
    set_pool(32'h0000_1000, 16'd24, 32'd0);
    add_req(OpCreate, 1'b0, 32'd0);
    set_pool(32'h0000_1000, 16'd24, 32'd31);
    add_req(OpCreate, 1'b0, 32'd0);
    // Two blocks: drain them, fail without waiting, fill the wait queue.
    set_pool(32'h0000_1000, 16'd24, 32'd64);
    add_req(OpCreate, 1'b0, 32'd0);
    add_req(OpAlloc, 1'b1, 32'd0);
    add_req(OpAlloc, 1'b0, 32'd0);
    add_req(OpAlloc, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i <= MaxWaiters; i++) add_req(OpAlloc, 1'b0, 32'd0);
    add_req(OpRelease, 1'b0, 32'h0000_1008);
    add_req(OpRelease, 1'b0, 32'h0000_1004);
    add_req(OpRelease, 1'b0, 32'h0000_1009);
    add_req(OpRelease, 1'b0, 32'h0000_1048);
    add_req(OpRelease, 1'b0, 32'h0000_1028);
    add_req(OpRelease, 1'b0, 32'h0000_1028);
    add_req(OpCreate, 1'b0, 32'd0);
    add_req(OpDelete, 1'b0, 32'd0);
    add_req(OpRelease, 1'b0, 32'h0000_1008);

    // Extremes: widest block, largest pool, top address, then the smallest block.
    set_pool(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    random_phase(20);
    set_pool(32'd0, 16'd1, 32'd9 * MaxBlocks);
    random_phase(30);

    // Mostly small pools, so that the stack empties and tasks queue up.
    for (int ph = 0; ph < 24; ph++) begin
      burst = ($urandom_range(0, 3) == 0);
      bs   = (ph % 7 == 6) ? 16'($urandom_range(1, 16'hFFFF)) : 16'($urandom_range(1, 64));
      nblk = $urandom_range(1, 12);
      if (ph % 9 == 8) nblk = 0;
      set_pool($urandom, bs, nblk * (bs + HeaderBytes) + $urandom_range(0, bs + 7));
      random_phase(26);
    end

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/fbpa_pkg.sv
sv/fbpa_div.sv
sv/fixed_block_pool_allocator.sv
bench/fixed_block_pool_allocator_test.sv
